### src/wheel30_first_sieve_multiple_core_assert.svh
// ----------------------------------------------------------------------------
// wheel30 first sieve multiple core assertion macros
// clocked property macros with and without reset qualification
// ----------------------------------------------------------------------------
`ifndef WHEEL30_FIRST_SIEVE_MULTIPLE_CORE_ASSERT_SVH
`define WHEEL30_FIRST_SIEVE_MULTIPLE_CORE_ASSERT_SVH

// property checked only while out of reset
`define WFSM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define WFSM_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/wfsm_pkg.sv
// ----------------------------------------------------------------------------
// wfsm_pkg
// shared types, widths and wheel helpers for the first sieve multiple core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfsm_pkg;

  localparam int P_W       = 32;
  localparam int S_W       = 64;
  localparam int RES_W     = 5;
  localparam int DIST_W    = 3;
  localparam int IN_W      = P_W + S_W;
  localparam int OUT_RAW_W = S_W + RES_W + 1;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int PAD_W     = OUT_W - OUT_RAW_W;
  localparam int CNT_W     = $clog2(S_W);
  localparam int WHEEL_MOD = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIV,
    ST_CEIL,
    ST_CLAMP,
    ST_WHEEL,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic div_step;
    logic p_shift;
    logic ceil;
    logic clamp;
    logic wheel;
    logic mul_lo;
    logic mul_hi;
    logic out_load;
  } cmd_t;

  // (2*m + b) mod 30 for m below 30
  function automatic logic [RES_W-1:0] mod30_shift(input logic [RES_W-1:0] m,
                                                   input logic b);
    logic [RES_W:0] s;
    s = {m, b};
    if (s >= (RES_W+1)'(WHEEL_MOD)) s = s - (RES_W+1)'(WHEEL_MOD);
    return s[RES_W-1:0];
  endfunction

  // (m + d) mod 30 for m below 30 and small d
  function automatic logic [RES_W-1:0] mod30_add(input logic [RES_W-1:0] m,
                                                 input logic [DIST_W-1:0] d);
    logic [RES_W:0] s;
    s = {1'b0, m} + (RES_W+1)'(d);
    if (s >= (RES_W+1)'(WHEEL_MOD)) s = s - (RES_W+1)'(WHEEL_MOD);
    return s[RES_W-1:0];
  endfunction

  // distance from residue r to the first residue at or above r that is coprime to 30
  function automatic logic [DIST_W-1:0] wheel_dist(input logic [RES_W-1:0] r);
    logic [DIST_W-1:0] d;
    case (r)
      5'd0:  d = 3'd1;
      5'd2:  d = 3'd5;
      5'd3:  d = 3'd4;
      5'd4:  d = 3'd3;
      5'd5:  d = 3'd2;
      5'd6:  d = 3'd1;
      5'd8:  d = 3'd3;
      5'd9:  d = 3'd2;
      5'd10: d = 3'd1;
      5'd12: d = 3'd1;
      5'd14: d = 3'd3;
      5'd15: d = 3'd2;
      5'd16: d = 3'd1;
      5'd18: d = 3'd1;
      5'd20: d = 3'd3;
      5'd21: d = 3'd2;
      5'd22: d = 3'd1;
      5'd24: d = 3'd5;
      5'd25: d = 3'd4;
      5'd26: d = 3'd3;
      5'd27: d = 3'd2;
      5'd28: d = 3'd1;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

### src/wfsm_ctrl.sv
// ----------------------------------------------------------------------------
// wfsm_ctrl
// sequencer for square, restoring divide, ceiling, clamp, wheel step and split multiply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output wfsm_pkg::cmd_t cmd
);
  import wfsm_pkg::*;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(S_W - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.p_shift  = !cnt_r[CNT_W-1];
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_CEIL;
      end
      ST_CEIL: begin
        cmd.ceil  = 1'b1;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_WHEEL;
      end
      ST_WHEEL: begin
        cmd.wheel = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

### src/wfsm_dp.sv
// ----------------------------------------------------------------------------
// wfsm_dp
// dividend, remainder, residue trackers, shared 32x32 multiplier, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfsm_dp (
  input  logic                       clk,
  input  wfsm_pkg::cmd_t             cmd,
  input  logic [wfsm_pkg::P_W-1:0]   prime,
  input  logic [wfsm_pkg::S_W-1:0]   chunk_start,
  output logic [wfsm_pkg::OUT_W-1:0] out_data
);
  import wfsm_pkg::*;

  localparam int HALF_W = S_W / 2;

  logic [P_W-1:0]   p_r;
  logic [S_W-1:0]   start_r;
  logic [S_W-1:0]   dvd_r, dvd_nxt;
  logic [P_W-1:0]   rem_r, rem_nxt;
  logic [RES_W-1:0] qm_r, qm_nxt;
  logic [RES_W-1:0] pm_r, pm_nxt;
  logic [P_W-1:0]   psh_r, psh_nxt;
  logic             khi_r, khi_nxt;
  logic [S_W-1:0]   lo_r;
  logic [S_W-1:0]   mul_r;
  logic [OUT_W-1:0] out_r, out_nxt;

  logic [P_W-1:0]    mul_a;
  logic [S_W-1:0]    prod;
  logic [P_W:0]      rem_sh;
  logic [P_W:0]      rem_diff;
  logic              ge;
  logic              inc;
  logic [DIST_W-1:0] step_d;
  logic [S_W:0]      ksum;
  logic [S_W:0]      sum;
  logic              ovf;

  always_comb begin
    case (1'b1)
      cmd.mul_lo: mul_a = dvd_r[HALF_W-1:0];
      cmd.mul_hi: mul_a = dvd_r[S_W-1:HALF_W];
      default:    mul_a = p_r;
    endcase
  end

  assign prod = mul_a * p_r;

  assign rem_sh   = {rem_r, dvd_r[S_W-1]};
  assign rem_diff = rem_sh - {1'b0, p_r};
  assign ge       = rem_sh >= {1'b0, p_r};
  assign inc      = (rem_r != '0) && (p_r != '0);
  assign step_d   = wheel_dist(qm_r);
  assign ksum     = {1'b0, dvd_r} + (S_W+1)'(step_d);
  assign sum      = {1'b0, lo_r} + {1'b0, mul_r[HALF_W-1:0], {HALF_W{1'b0}}};
  assign ovf      = (mul_r[S_W-1:HALF_W] != '0) || sum[S_W] || (khi_r && (p_r != '0));

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    qm_nxt  = qm_r;
    pm_nxt  = pm_r;
    psh_nxt = psh_r;
    khi_nxt = khi_r;
    out_nxt = out_r;
    if (cmd.square) begin
      dvd_nxt = (start_r == '0) ? prod : start_r;
      rem_nxt = '0;
      qm_nxt  = '0;
      pm_nxt  = '0;
      psh_nxt = p_r;
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? rem_diff[P_W-1:0] : rem_sh[P_W-1:0];
      dvd_nxt = {dvd_r[S_W-2:0], ge};
      qm_nxt  = mod30_shift(qm_r, ge);
      if (cmd.p_shift) begin
        pm_nxt  = mod30_shift(pm_r, psh_r[P_W-1]);
        psh_nxt = {psh_r[P_W-2:0], 1'b0};
      end
    end
    if (cmd.ceil) begin
      dvd_nxt = dvd_r + S_W'(inc);
      qm_nxt  = mod30_add(qm_r, DIST_W'(inc));
    end
    if (cmd.clamp && (dvd_r < {{(S_W-P_W){1'b0}}, p_r})) begin
      dvd_nxt = {{(S_W-P_W){1'b0}}, p_r};
      qm_nxt  = pm_r;
    end
    if (cmd.wheel) begin
      dvd_nxt = ksum[S_W-1:0];
      khi_nxt = ksum[S_W];
      qm_nxt  = mod30_add(qm_r, step_d);
    end
    if (cmd.out_load) begin
      out_nxt = {{PAD_W{1'b0}}, ovf, qm_r, sum[S_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r     <= prime;
      start_r <= chunk_start;
    end
    if (cmd.mul_lo) lo_r <= prod;
    if (cmd.mul_hi) mul_r <= prod;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    qm_r  <= qm_nxt;
    pm_r  <= pm_nxt;
    psh_r <= psh_nxt;
    khi_r <= khi_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### src/wheel30_first_sieve_multiple_core.sv
// ----------------------------------------------------------------------------
// sequence per transaction: square, 64-step bit-serial divide, ceiling, clamp,
//   wheel step and two passes of the 32x32 multiplier, then the result load
// one transaction at a time; the result load waits while a stalled result is held
// reset: rst_n low clears the sequencer and drops out_tvalid; data is not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel30_first_sieve_multiple_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [wfsm_pkg::IN_W-1:0]  in_tdata,   // prime, chunk_start
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [wfsm_pkg::OUT_W-1:0] out_tdata   // multiple, k_residue, overflow
);
  import wfsm_pkg::*;

  cmd_t cmd;

  wfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  wfsm_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .prime      (in_tdata[P_W-1:0]),
    .chunk_start(in_tdata[IN_W-1:P_W]),
    .out_data   (out_tdata)
  );

endmodule

### src/wfsm_checker.sv
// ----------------------------------------------------------------------------
// wfsm_checker
// port level checks for the first sieve multiple core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wheel30_first_sieve_multiple_core_assert.svh"

module wfsm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [wfsm_pkg::IN_W-1:0]  in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [wfsm_pkg::OUT_W-1:0] out_tdata
);
  import wfsm_pkg::*;

  logic [RES_W-1:0] res;
  logic             res_ok;
  logic             in_xfer;

  assign res     = out_tdata[S_W+RES_W-1:S_W];
  assign res_ok  = res inside {5'd1, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29};
  assign in_xfer = in_tvalid && in_tready && (in_tdata == in_tdata);

  // one item at a time: no new transaction right after one is taken
  `WFSM_ASSERT_RST(a_busy_after_accept, in_xfer |=> !in_tready, "accepted while busy")
  // a reported residue is always on the wheel
  `WFSM_ASSERT_RST(a_res_on_wheel, out_tvalid |-> res_ok, "residue off wheel")
  // stalled result holds
  `WFSM_ASSERT_RST(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  // reset empties the output
  `WFSM_ASSERT_ALL(a_rst_empty, !rst_n |=> !out_tvalid, "out_tvalid after reset")

endmodule

bind wheel30_first_sieve_multiple_core wfsm_checker u_wfsm_checker (.*);

### dv/tb_wheel30_first_sieve_multiple_core.sv
// ----------------------------------------------------------------------------
// tb_wheel30_first_sieve_multiple_core
// self-checking bench for the wheel-30 first sieve multiple core: a directed
// set of corner primes and starts followed by about 430 random transactions,
// each predicted in the bench and checked field by field, with random gaps
// and stalls on both streams and one long stall on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wheel30_first_sieve_multiple_core;
  import wfsm_pkg::*;

  localparam int          RESET_CYCLES = 11;
  localparam int          RANDOM_ITEMS = 430;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          LONG_HOLD    = 700;
  localparam int          HOLD_AT_HIT  = 40;
  localparam logic [63:0] ALL_ONES     = '1;

  typedef struct packed {
    logic [31:0] prime;
    logic [63:0] start;
  } sieve_req_t;

  typedef struct packed {
    logic [63:0] multiple;
    logic [4:0]  k_residue;
    logic        overflow;
  } sieve_hit_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;   // prime, chunk_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;         // multiple, k_residue, overflow

  sieve_req_t req_q[$];
  sieve_hit_t hit_q[$];
  int         req_total   = 0;
  int         primes_sent = 0;
  int         hits_seen   = 0;
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         hold_left   = 0;
  bit         hold_done   = 1'b0;
  bit         in_acc      = 1'b0;
  bit         out_acc     = 1'b0;
  bit         in_calm     = 1'b0;
  bit         out_calm    = 1'b0;
  int         in_gap      = 0;
  int         out_gap     = 0;

  wheel30_first_sieve_multiple_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // first k*p at or above the start with k >= p and k coprime to 30
  function automatic sieve_hit_t first_wheel_multiple(input logic [31:0] prime,
                                                      input logic [63:0] start);
    logic [63:0]  p64;
    logic [63:0]  base;
    logic [63:0]  k;
    logic [64:0]  k_wide;
    logic [127:0] prod;
    int unsigned  r;
    int unsigned  d;
    int unsigned  rr;
    sieve_hit_t   hit;
    p64  = {32'd0, prime};
    base = (start == 64'd0) ? p64 * p64 : start;
    if (prime == 32'd0) begin
      k = ALL_ONES;
    end else begin
      k = base / p64;
      if (base % p64 != 64'd0) k = k + 64'd1;
    end
    if (k < p64) k = p64;
    r = int'(k % 64'(WHEEL_MOD));
    for (d = 0; d < 7; d++) begin
      rr = (r + d) % WHEEL_MOD;
      if (rr % 2 != 0 && rr % 3 != 0 && rr % 5 != 0) break;
    end
    k_wide        = {1'b0, k} + 65'(d);
    prod          = {64'd0, k_wide[63:0]} * {96'd0, prime};
    hit.multiple  = prod[63:0];
    hit.k_residue = 5'((r + d) % WHEEL_MOD);
    hit.overflow  = (prod[127:64] != 64'd0) || (k_wide[64] && prime != 32'd0);
    return hit;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // reset, stimulus and end of run
  initial begin
    sieve_req_t req;
    logic [31:0] p;
    logic [63:0] s;
    rst_n = 1'b0;

    // directed corners
    req_q.push_back('{32'd0, 64'd0});
    req_q.push_back('{32'd0, {$urandom, $urandom}});
    req_q.push_back('{32'd0, ALL_ONES});
    req_q.push_back('{32'd7, 64'd0});
    req_q.push_back('{32'd11, 64'd0});
    req_q.push_back('{32'hFFFF_FFFF, 64'd0});
    req_q.push_back('{32'hFFFF_FFFF, ALL_ONES});
    req_q.push_back('{32'h8000_0000, ALL_ONES});
    req_q.push_back('{32'd7, ALL_ONES});
    req_q.push_back('{32'd1, ALL_ONES});
    req_q.push_back('{32'd1, ALL_ONES - 64'd1});
    req_q.push_back('{32'd1, ALL_ONES - 64'd5});
    req_q.push_back('{32'd1, 64'd0});
    req_q.push_back('{32'd2, 64'd0});
    req_q.push_back('{32'd3, 64'd100});
    req_q.push_back('{32'd5, 64'd1});
    req_q.push_back('{32'd4, 64'd0});
    req_q.push_back('{32'd6, 64'd12345});
    req_q.push_back('{32'd7, 64'd1});
    req_q.push_back('{32'd7, 64'd49});
    req_q.push_back('{32'd7, 64'd50});
    req_q.push_back('{32'd65521, 64'd65521 * 64'd1_000_003});
    req_q.push_back('{32'd65521, 64'd65521 * 64'd1_000_003 + 64'd1});
    req_q.push_back('{32'hFFFF_FFFB, 64'h8000_0000_0000_0000});

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: p = $urandom;
        3, 4, 5: p = $urandom_range(7, 2000);
        6, 7:    p = {4'hF, 28'($urandom)};
        8:       p = $urandom_range(0, 6);
        default: p = $urandom_range(2001, 32'h00FF_FFFF);
      endcase
      case ($urandom_range(0, 9))
        0:       s = 64'd0;
        1, 2:    s = {$urandom, $urandom};
        3:       s = 64'($urandom_range(0, 100000));
        4:       s = ALL_ONES - 64'($urandom_range(0, 1000));
        5, 6:    s = 64'(p) * 64'($urandom) + 64'($urandom_range(0, 2)) - 64'd1;
        7:       s = 64'(p) * 64'(p) - 64'($urandom_range(0, 3));
        8:       s = {1'b1, 31'($urandom), $urandom};
        default: s = {32'($urandom_range(0, 255)), $urandom};
      endcase
      req.prime = p;
      req.start = s;
      req_q.push_back(req);
    end
    req_total = req_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (primes_sent != req_total || hit_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // input driver
  always @(negedge clk) begin
    sieve_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_acc)) begin
      if (in_acc) begin
        in_acc  = 1'b0;
        in_calm = ($urandom_range(0, 39) == 0) ? !in_calm : in_calm;
        in_gap  = draw_wait(in_calm);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        req = req_q.pop_front();
        in_tdata  <= {req.start, req.prime};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long result-side hold once HOLD_AT_HIT results have been seen
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && hits_seen == HOLD_AT_HIT) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_acc) begin
        out_acc  = 1'b0;
        out_calm = ($urandom_range(0, 39) == 0) ? !out_calm : out_calm;
        out_gap  = draw_wait(out_calm);
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input transactions, check on result transactions
  always @(posedge clk) begin
    sieve_hit_t want;
    sieve_hit_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_acc       = 1'b1;
        hits_seen    <= hits_seen + 1;
        got.multiple  = out_tdata[63:0];
        got.k_residue = out_tdata[68:64];
        got.overflow  = out_tdata[69];
        if (hit_q.size() == 0) begin
          $error("unexpected result transaction, data %h", out_tdata);
          mismatches++;
        end else begin
          want = hit_q.pop_front();
          if (got.multiple !== want.multiple) begin
            $error("multiple: expected %h, got %h", want.multiple, got.multiple);
            mismatches++;
          end
          if (got.k_residue !== want.k_residue) begin
            $error("k_residue: expected %0d, got %0d", want.k_residue, got.k_residue);
            mismatches++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        in_acc       = 1'b1;
        primes_sent <= primes_sent + 1;
        hit_q.push_back(first_wheel_multiple(in_tdata[31:0], in_tdata[95:32]));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

### files.f
+incdir+src
src/wfsm_pkg.sv
src/wfsm_ctrl.sv
src/wfsm_dp.sv
src/wheel30_first_sieve_multiple_core.sv
src/wfsm_checker.sv
dv/tb_wheel30_first_sieve_multiple_core.sv
